[sv/assert_macros.svh]
// Assertion macros shared by the rotated sorted array search RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, disabled while reset is asserted.
`define RSAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock, also during reset.
`define RSAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rsas_pkg.sv]
// Package for the rotated sorted array search block.
// Holds the item payload types and fixed field widths; no dependencies.
package rsas_pkg;

    localparam int unsigned POS_W   = 10;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned COUNT_W = 11;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  element;
        logic signed [VAL_W-1:0]  target;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_index;
    } t_rsp;

endpackage

[sv/rotated_sorted_array_search.sv]
// Top level of the rotated sorted array search block.
// Depends on rsas_pkg, rsas_mem and rsas_search.

// A load item (mode 0) writes one element in the cycle it is accepted and
// gives no result; positions at or beyond DEPTH are dropped. A search item
// (mode 1) runs a binary search over the first element_count entries of the
// element store, read through its registered two-port memory. Each probe
// reads the mid and low entries and then compares; when the right half is
// sorted, the high entry is read as well before a second compare. o_done is
// registered from the compare that finds a match, or from the read step that
// finds the range empty, which is the first step for a count of zero; for
// 1024 elements a search makes at most 11 probes. busy is high from the
// cycle after accept until the
// result strobe. o_done is high for exactly one cycle with o_rsp valid; the
// receiver cannot stall it, so it must take the item in that cycle. A new
// item may be started in the o_done cycle.
module rotated_sorted_array_search import rsas_pkg::*; #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    output logic               o_done,
    output t_rsp               o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);

    logic [COUNT_W-1:0]    r_count;
    logic                  accept;
    logic                  load_we;
    logic                  search_go;
    logic [LW-1:0]         count_sat;
    logic [DATA_WIDTH-1:0] element_ord;
    logic [DATA_WIDTH-1:0] target_ord;
    logic                  rd_en;
    logic [AW-1:0]         raddr_a;
    logic [AW-1:0]         raddr_b;
    logic [DATA_WIDTH-1:0] rdata_a;
    logic [DATA_WIDTH-1:0] rdata_b;

    // Sign-extend, cut to the store width, flip the sign so unsigned order
    // matches signed order.
    function automatic logic [DATA_WIDTH-1:0] to_ordered(logic [VAL_W-1:0] v);
        logic [63:0] ext;
        logic [DATA_WIDTH-1:0] cut;
        ext = {{(64-VAL_W){v[VAL_W-1]}}, v};
        cut = DATA_WIDTH'(ext);
        cut[DATA_WIDTH-1] = ~cut[DATA_WIDTH-1];
        return cut;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    assign accept      = start && !busy;
    assign load_we     = accept && (i_req.mode == MODE_LOAD)
                         && (32'(i_req.position) < 32'(DEPTH));
    assign search_go   = accept && (i_req.mode == MODE_SEARCH);
    assign count_sat   = (32'(r_count) > 32'(DEPTH)) ? LW'(DEPTH) : LW'(r_count);
    assign element_ord = to_ordered(i_req.element);
    assign target_ord  = to_ordered(i_req.target);

    rsas_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (load_we),
        .i_waddr   (AW'(i_req.position)),
        .i_wdata   (element_ord),
        .i_re      (rd_en),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    rsas_search #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (search_go),
        .i_target  (target_ord),
        .i_count   (count_sat),
        .o_busy    (busy),
        .o_re      (rd_en),
        .o_raddr_a (raddr_a),
        .o_raddr_b (raddr_b),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_done    (o_done),
        .o_rsp     (o_rsp)
    );

endmodule

[sv/rsas_mem.sv]
// Element store: one write port, two registered read ports.
// Uses no package; sized by the top level parameters.
module rsas_mem #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [DATA_WIDTH-1:0]        i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr_b,
    output logic [DATA_WIDTH-1:0]        o_rdata_a,
    output logic [DATA_WIDTH-1:0]        o_rdata_b
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata_a;
    logic [DATA_WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[sv/rsas_search.sv]
// Probe sequencer for the rotated binary search over the element store.
// Depends on rsas_pkg and assert_macros.svh; drives the rsas_mem read ports.
`include "assert_macros.svh"

module rsas_search import rsas_pkg::*; #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic [DATA_WIDTH-1:0]             i_target,
    input  logic [$clog2(DEPTH+1)-1:0]        i_count,
    output logic                              o_busy,
    output logic                              o_re,
    output logic [$clog2(DEPTH)-1:0]          o_raddr_a,
    output logic [$clog2(DEPTH)-1:0]          o_raddr_b,
    input  logic [DATA_WIDTH-1:0]             i_rdata_a,
    input  logic [DATA_WIDTH-1:0]             i_rdata_b,
    output logic                              o_done,
    output t_rsp                              o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_CMP   = 4'b0100,
        S_RIGHT = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [LW-1:0]         r_low, n_low;
    logic [LW-1:0]         r_hi_ex, n_hi_ex;     // one past the high bound
    logic [AW-1:0]         r_mid, n_mid;
    logic [DATA_WIDTH-1:0] r_target, n_target;
    logic [DATA_WIDTH-1:0] r_vm, n_vm;
    logic                  r_done, n_done;
    t_rsp                  r_rsp, n_rsp;

    logic                  nonempty;
    logic [LW:0]           mid_sum;
    logic [AW-1:0]         mid_c;
    logic [AW-1:0]         high_addr;
    logic                  left_sorted;

    assign nonempty    = r_low < r_hi_ex;
    assign mid_sum     = {1'b0, r_low} + {1'b0, r_hi_ex} - (LW+1)'(1);
    assign mid_c       = AW'(mid_sum[LW:1]);
    assign high_addr   = AW'(r_hi_ex - LW'(1));
    assign left_sorted = i_rdata_b <= i_rdata_a;

    always_comb begin
        n_state  = r_state;
        n_low    = r_low;
        n_hi_ex  = r_hi_ex;
        n_mid    = r_mid;
        n_target = r_target;
        n_vm     = r_vm;
        n_done   = 1'b0;
        n_rsp    = r_rsp;
        o_re      = 1'b0;
        o_raddr_a = mid_c;
        o_raddr_b = r_low[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_low    = '0;
                    n_hi_ex  = i_count;
                    n_target = i_target;
                    n_state  = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (nonempty) begin
                    // fetch mid and low entries
                    o_re    = 1'b1;
                    n_mid   = mid_c;
                    n_state = S_CMP;
                end else begin
                    n_done  = 1'b1;
                    n_rsp   = '{found: 1'b0, match_index: '0};
                    n_state = S_IDLE;
                end
            end
            S_CMP: begin
                o_raddr_a = high_addr;
                if (i_rdata_a == r_target) begin
                    n_done  = 1'b1;
                    n_rsp   = '{found: 1'b1, match_index: POS_W'(r_mid)};
                    n_state = S_IDLE;
                end else if (left_sorted) begin
                    if (i_rdata_b <= r_target && r_target < i_rdata_a) begin
                        n_hi_ex = LW'(r_mid);
                    end else begin
                        n_low = LW'(r_mid) + LW'(1);
                    end
                    n_state = S_ISSUE;
                end else begin
                    // right half sorted: need the high entry too
                    o_re    = 1'b1;
                    n_vm    = i_rdata_a;
                    n_state = S_RIGHT;
                end
            end
            S_RIGHT: begin
                if (r_vm < r_target && r_target <= i_rdata_a) begin
                    n_low = LW'(r_mid) + LW'(1);
                end else begin
                    n_hi_ex = LW'(r_mid);
                end
                n_state = S_ISSUE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low    <= n_low;
        r_hi_ex  <= n_hi_ex;
        r_mid    <= n_mid;
        r_target <= n_target;
        r_vm     <= n_vm;
        r_rsp    <= n_rsp;
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `RSAS_ASSERT(a_done_after_search, i_clk, i_rst_n, r_done |-> $past(r_state != S_IDLE), "result strobe without a search")
    `RSAS_ASSERT(a_done_single, i_clk, i_rst_n, r_done |=> !r_done, "result strobe longer than one cycle")
    `RSAS_ASSERT(a_mid_in_range, i_clk, i_rst_n, (r_state == S_CMP) |-> (LW'(r_mid) >= r_low && LW'(r_mid) < r_hi_ex), "probe outside the search range")
    `RSAS_ASSERT(a_found_match, i_clk, i_rst_n, (r_done && r_rsp.found) |-> $past(r_state == S_CMP), "match reported without a compare")
    `RSAS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_done), "reset did not clear the sequencer")

endmodule

[verif/tb.sv]
// Self-checking bench for rotated_sorted_array_search: loads arrays, sets the
// element count and checks every search answer against an in-bench predictor.
// Depends on rsas_pkg and the rotated_sorted_array_search RTL.
module tb;
    import rsas_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int RANDOM_ITEMS  = 100;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam longint SPAN      = 64'd4294967295;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [COUNT_W-1:0] i_cfg_wdata = '0;
    logic               start       = 1'b0;
    t_req               i_req       = '0;
    logic               busy;
    logic               o_done;
    t_rsp               o_rsp;

    rotated_sorted_array_search i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: copy of the element store and the active count.
    logic signed [VAL_W-1:0] array_copy [0:DEPTH-1];
    logic [COUNT_W-1:0]      search_span = '0;

    // Generator view: what has been queued for each position.
    logic signed [VAL_W-1:0] plan_val [0:DEPTH-1];
    bit                      plan_set [0:DEPTH-1];
    logic signed [VAL_W-1:0] staged   [0:DEPTH-1];

    t_req queued_items [$];
    t_rsp expected_answers [$];

    int  n_queued   = 0;
    int  n_accepted = 0;
    int  n_loads    = 0;
    int  n_searches = 0;
    int  n_checked  = 0;
    int  n_settings = 0;
    int  mismatches = 0;
    int  gap_left   = 0;
    int  cycle_cnt  = 0;
    bit  steady     = 1'b0;

    function automatic t_rsp predict_search(logic signed [VAL_W-1:0] goal);
        t_rsp answer;
        int   n;
        int   lo;
        int   hi;
        int   mid;
        logic signed [VAL_W-1:0] v_lo;
        logic signed [VAL_W-1:0] v_mid;
        answer = '0;
        n  = (int'(search_span) > DEPTH) ? DEPTH : int'(search_span);
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid   = (lo + hi) / 2;
            v_mid = array_copy[mid];
            v_lo  = array_copy[lo];
            if (v_mid == goal) begin
                answer.found       = 1'b1;
                answer.match_index = POS_W'(mid);
                return answer;
            end
            if (v_lo <= v_mid) begin
                // left half sorted
                if (v_lo <= goal && goal < v_mid) hi = mid - 1;
                else lo = mid + 1;
            end else begin
                if (v_mid < goal && goal <= array_copy[hi]) lo = mid + 1;
                else hi = mid - 1;
            end
        end
        return answer;
    endfunction

    // Driver: hold the item until accepted, then wait the drawn gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                if (i_req.mode == MODE_SEARCH) begin
                    expected_answers.push_back(predict_search(i_req.target));
                    n_searches++;
                end else begin
                    array_copy[i_req.position] = i_req.element;
                    n_loads++;
                end
                n_accepted++;
                gap_left = steady ? 0 : $urandom_range(0, 16);
            end
            if (!(start && busy)) begin
                if (gap_left == 0 && queued_items.size() != 0) begin
                    start <= 1'b1;
                    i_req <= queued_items.pop_front();
                end else begin
                    start <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    // Monitor: every strobed answer must match the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected answer found=%0b index=%0d, none expected",
                         $time, o_rsp.found, o_rsp.match_index);
                mismatches++;
            end else begin
                want = expected_answers.pop_front();
                n_checked++;
                if (o_rsp.found !== want.found) begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, o_rsp.found);
                    mismatches++;
                end
                if (o_rsp.match_index !== want.match_index) begin
                    $display("%0t: match_index expected %0d actual %0d",
                             $time, want.match_index, o_rsp.match_index);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_load(input int pos, input logic signed [VAL_W-1:0] v);
        t_req item;
        item.mode     = MODE_LOAD;
        item.position = POS_W'(pos);
        item.element  = v;
        item.target   = $urandom;
        queued_items.push_back(item);
        n_queued++;
        plan_val[pos] = v;
        plan_set[pos] = 1'b1;
    endtask

    task automatic push_search(input logic signed [VAL_W-1:0] goal);
        t_req item;
        item.mode     = MODE_SEARCH;
        item.position = POS_W'($urandom);
        item.element  = $urandom;
        item.target   = goal;
        queued_items.push_back(item);
        n_queued++;
    endtask

    // Wait until every item is taken and answered, then let the block go quiet.
    task automatic drain_block();
        while (n_accepted != n_queued || expected_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_count(input int v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= COUNT_W'(v);
        search_span = COUNT_W'(v);
        n_settings++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int written_prefix();
        int k;
        k = 0;
        while (k < DEPTH && plan_set[k]) k++;
        return k;
    endfunction

    // Build an ascending run (distinct or with repeats) and rotate it.
    task automatic stage_rotated(input int n, input bit with_dups);
        longint seq [DEPTH];
        longint step_max;
        longint base;
        int     pivot;
        int     k;
        step_max = $urandom_range(1, 32'(SPAN / n));
        seq[0] = 0;
        for (k = 1; k < n; k++) begin
            seq[k] = seq[k-1] + (with_dups ? longint'($urandom_range(0, 3))
                                           : longint'($urandom_range(1, 32'(step_max))));
        end
        base  = -longint'(64'd2147483648) + longint'($urandom_range(0, 32'(SPAN - seq[n-1])));
        pivot = $urandom_range(0, n - 1);
        for (k = 0; k < n; k++) staged[k] = VAL_W'(base + seq[(k + pivot) % n]);
    endtask

    task automatic load_staged(input int n);
        int off;
        bit rev;
        int k;
        int pos;
        off = $urandom_range(0, n - 1);
        rev = $urandom_range(0, 1);
        for (k = 0; k < n; k++) begin
            pos = (off + k) % n;
            if (rev) pos = n - 1 - pos;
            push_load(pos, staged[pos]);
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_target(input int cnt);
        int roll;
        int lim;
        logic signed [VAL_W-1:0] v;
        roll = $urandom_range(0, 99);
        lim  = (cnt > DEPTH) ? DEPTH : cnt;
        if (lim > 0) v = plan_val[$urandom_range(0, lim - 1)];
        else v = $urandom;
        if (roll < 55) return v;
        if (roll < 70) return $urandom_range(0, 1) ? v + 1 : v - 1;
        if (roll < 80) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        int base;
        int roll;
        int n;
        int cnt;
        int k;
        int settle;
        int full_counts [3];
        full_counts = '{DEPTH, 2047, DEPTH - 1};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Count is zero after reset: nothing can be found.
        push_search('0);
        push_search(VAL_MIN);
        push_search(VAL_MAX);

        // Small rotated array spanning both value extremes.
        push_load(0, 32'sd5);
        push_load(1, 32'sd100);
        push_load(2, VAL_MAX);
        push_load(3, VAL_MIN);
        push_load(4, -32'sd7);
        push_load(5, 32'sd0);
        push_load(6, 32'sd1);
        push_load(7, 32'sd3);
        drain_block();
        set_count(8);
        push_search(VAL_MAX);
        push_search(VAL_MIN);
        push_search(32'sd5);
        push_search(32'sd3);
        push_search(32'sd2);
        push_search(32'sd101);
        push_search(32'sd0);
        push_search(-32'sd8);
        drain_block();
        set_count(1);
        push_search(32'sd5);
        push_search(32'sd6);

        // Random arrays: mostly rotated sorted runs, some with repeats or noise.
        base = n_queued;
        while (n_queued - base < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) n = $urandom_range(1, 16);
            else if (roll < 92) n = $urandom_range(17, 64);
            else n = $urandom_range(65, 128);
            roll = $urandom_range(0, 99);
            if (roll < 80) stage_rotated(n, 1'b0);
            else if (roll < 90) stage_rotated(n, 1'b1);
            else for (k = 0; k < n; k++) staged[k] = $urandom;
            steady = ($urandom_range(0, 3) == 0);
            load_staged(n);
            drain_block();
            cnt = ($urandom_range(0, 4) != 0) ? n : $urandom_range(0, written_prefix());
            set_count(cnt);
            repeat ($urandom_range(3, 12)) begin
                if ($urandom_range(0, 9) == 0) push_load($urandom_range(0, DEPTH - 1), $urandom);
                push_search(pick_target(cnt));
            end
        end

        // Fill the whole store, then search at full depth and beyond it.
        steady = 1'b0;
        stage_rotated(DEPTH, 1'b0);
        load_staged(DEPTH);
        foreach (full_counts[i]) begin
            drain_block();
            set_count(full_counts[i]);
            repeat (10) push_search(pick_target(full_counts[i]));
        end
        drain_block();
        set_count(0);
        repeat (3) push_search(pick_target(DEPTH));

        while (n_accepted != n_queued) @(posedge i_clk);
        settle = 0;
        while (expected_answers.size() != 0 && settle < 200) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_answers.size() != 0) begin
            $display("%0t: %0d expected answers never arrived", $time,
                     expected_answers.size());
            mismatches += expected_answers.size();
        end

        $display("ran %0d loads and %0d searches over %0d count settings, 0 through 2047",
                 n_loads, n_searches, n_settings);
        $display("compared %0d answers, %0d field mismatches", n_checked, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
